### hw/rtl/chunk_box_frustum_cull_assert.svh
// Assertion macros for the checker in cbfc_check.sv.
`ifndef CHUNK_BOX_FRUSTUM_CULL_ASSERT_SVH
`define CHUNK_BOX_FRUSTUM_CULL_ASSERT_SVH

// Implication checked in the same cycle, masked during reset.
`define CBFC_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Implication checked in the next cycle, masked during reset.
`define CBFC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

// Implication checked in the next cycle, also across reset.
`define CBFC_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### hw/rtl/cbfc_pkg.sv
package cbfc_pkg;

  localparam int CHUNK_SIZE = 16;
  localparam int BOX_TOP    = 255;

  localparam int CHUNK_W    = 16;
  localparam int NUM_PLANES = 6;
  localparam int REG_N      = 8;
  localparam int CFG_W      = 64;
  localparam int CFG_IDX_W  = $clog2(REG_N);

  // x1 = (chunk_x + 1) * CHUNK_SIZE needs one bit beyond the field plus the size bits
  localparam int COORD_W = CHUNK_W + 1 + $clog2(CHUNK_SIZE + 1);
  localparam int COEF_W  = 33;
  localparam int PROD_W  = COEF_W + COORD_W;
  localparam int VAL_W   = PROD_W + 2;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [COEF_W-1:0]  coef_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [VAL_W-1:0]   val_t;
  typedef logic [REG_N-1:0][CFG_W-1:0] cfg_bank_t;

  // Identity matrix, 1.0 = 0x10000 on the diagonal; register 7 first.
  localparam cfg_bank_t CFG_RESET = {
    64'h0001_0000_0000_0000,  // col3_rows23
    64'h0000_0000_0000_0000,  // col3_rows01
    64'h0000_0000_0001_0000,  // col2_rows23
    64'h0000_0000_0000_0000,  // col2_rows01
    64'h0000_0000_0000_0000,  // col1_rows23
    64'h0001_0000_0000_0000,  // col1_rows01
    64'h0000_0000_0000_0000,  // col0_rows23
    64'h0000_0000_0001_0000   // col0_rows01
  };

  // Matrix row combined with row 3 for each plane, and whether it is subtracted.
  localparam int PLANE_ROW [NUM_PLANES] = '{0, 0, 1, 1, 2, 2};
  localparam bit PLANE_NEG [NUM_PLANES] = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0};

  typedef struct packed {
    coef_t a;
    coef_t c;
    val_t  k;     // d plus the best y term
    logic  flat;  // normal is all zero
  } plane_t;

  typedef struct packed {
    logic   valid;
    logic   vis;
    coord_t x0;
    coord_t x1;
    coord_t z0;
    coord_t z1;
  } item_t;

endpackage

### hw/rtl/cbfc_req_if.sv
interface cbfc_req_if;
  logic                                valid;
  logic                                ready;
  logic signed [cbfc_pkg::CHUNK_W-1:0] chunk_x;
  logic signed [cbfc_pkg::CHUNK_W-1:0] chunk_z;

  modport source (output valid, output chunk_x, output chunk_z, input ready);
  modport sink (input valid, input chunk_x, input chunk_z, output ready);
endinterface

### hw/rtl/cbfc_rsp_if.sv
interface cbfc_rsp_if;
  logic valid;
  logic ready;
  logic visible;

  modport source (output valid, output visible, input ready);
  modport sink (input valid, input visible, output ready);
endinterface

### hw/rtl/cbfc_plane.sv
module cbfc_plane (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      cfg_we,
  input  logic [cbfc_pkg::CFG_IDX_W-1:0]            cfg_index,
  input  logic [cbfc_pkg::CFG_W-1:0]                cfg_data,
  output cbfc_pkg::plane_t [cbfc_pkg::NUM_PLANES-1:0] planes
);

  cbfc_pkg::cfg_bank_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= cbfc_pkg::CFG_RESET;
    end else if (cfg_we) begin
      cfg[cfg_index] <= cfg_data;
    end
  end

  for (genvar p = 0; p < cbfc_pkg::NUM_PLANES; p++) begin : g_plane
    cbfc_pkg::coef_t co [4];

    for (genvar k = 0; k < 4; k++) begin : g_coef
      // column k lives in registers 2k (rows 0,1) and 2k+1 (rows 2,3)
      localparam int RI = k * 2 + cbfc_pkg::PLANE_ROW[p] / 2;
      localparam int HI = (cbfc_pkg::PLANE_ROW[p] % 2) * 32;
      cbfc_pkg::coef_t r3;
      cbfc_pkg::coef_t ri;
      assign r3 = cbfc_pkg::coef_t'(signed'(cfg[k * 2 + 1][63:32]));
      assign ri = cbfc_pkg::coef_t'(signed'(cfg[RI][HI +: 32]));
      assign co[k] = cbfc_pkg::PLANE_NEG[p] ? (r3 - ri) : (r3 + ri);
    end

    assign planes[p].a    = co[0];
    assign planes[p].c    = co[2];
    assign planes[p].flat = (co[0] == '0) && (co[1] == '0) && (co[2] == '0);
    // y spans 0..BOX_TOP: take the top only when b is positive
    assign planes[p].k = cbfc_pkg::val_t'(co[3]) +
        ((co[1] > 0) ? cbfc_pkg::val_t'(co[1]) * cbfc_pkg::val_t'(cbfc_pkg::BOX_TOP)
                     : cbfc_pkg::val_t'(0));
  end

endmodule

### hw/rtl/cbfc_cell.sv
module cbfc_cell (
  input  logic              clk,
  input  logic              rst,
  input  cbfc_pkg::plane_t  plane,
  input  cbfc_pkg::item_t   up,
  output logic              up_ready,
  output cbfc_pkg::item_t   down,
  input  logic              down_ready
);

  // stage 1: products of the nearest-to-positive corner
  logic            s1_valid;
  logic            s1_vis;
  cbfc_pkg::coord_t s1_x0, s1_x1, s1_z0, s1_z1;
  cbfc_pkg::prod_t s1_pa;
  cbfc_pkg::prod_t s1_pc;
  // stage 2: plane verdict
  cbfc_pkg::item_t s2;

  cbfc_pkg::coord_t xsel;
  cbfc_pkg::coord_t zsel;
  cbfc_pkg::val_t   sum;
  logic             s1_ready;
  logic             s2_ready;

  assign xsel = (plane.a > 0) ? up.x1 : up.x0;
  assign zsel = (plane.c > 0) ? up.z1 : up.z0;
  assign sum  = cbfc_pkg::val_t'(s1_pa) + cbfc_pkg::val_t'(s1_pc) + plane.k;

  assign s2_ready = !s2.valid || down_ready;
  assign s1_ready = !s1_valid || s2_ready;
  assign up_ready = s1_ready;
  assign down     = s2;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= up.valid;
    end
    if (s1_ready && up.valid) begin
      s1_vis <= up.vis && !plane.flat;
      s1_x0  <= up.x0;
      s1_x1  <= up.x1;
      s1_z0  <= up.z0;
      s1_z1  <= up.z1;
      s1_pa  <= cbfc_pkg::prod_t'(plane.a) * cbfc_pkg::prod_t'(xsel);
      s1_pc  <= cbfc_pkg::prod_t'(plane.c) * cbfc_pkg::prod_t'(zsel);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2.valid <= 1'b0;
    end else if (s2_ready) begin
      s2.valid <= s1_valid;
    end
    if (s2_ready && s1_valid) begin
      s2.vis <= s1_vis && (sum > 0);
      s2.x0  <= s1_x0;
      s2.x1  <= s1_x1;
      s2.z0  <= s1_z0;
      s2.z1  <= s1_z1;
    end
  end

endmodule

### hw/rtl/chunk_box_frustum_cull.sv
// Chunk column frustum cull.
// chunk (request channel, valid/ready): grid chunk_x and chunk_z of one chunk.
// result (valid/ready): one bit per request, visible = 1 when the column box
//   x*S..x*S+S, 0..BOX_TOP, z*S..z*S+S lies at least partly inside all six
//   planes taken from the view-projection matrix; 0 when culled.
// cfg_we/cfg_index/cfg_data: write the eight 64-bit matrix registers; write only
//   while no request is in flight. The planes follow a write in the next cycle.
// The pipe is one coordinate stage, then six plane cells of two stages each
// (multiply, then sum and sign).
// Throughput is one request per cycle; every stage has its own valid bit, so
// requests keep entering while a result waits, until the bubbles run out.
// When the receiver stalls, the result holds and the pipe backs up stage by
// stage; chunk.ready drops once the whole row is full.
// Synchronous reset empties the pipe and loads the identity matrix.
module chunk_box_frustum_cull (
  input  logic                           clk,
  input  logic                           rst,
  cbfc_req_if.sink                       chunk,
  cbfc_rsp_if.source                     result,
  input  logic                           cfg_we,
  input  logic [cbfc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cbfc_pkg::CFG_W-1:0]     cfg_data
);

  cbfc_pkg::plane_t [cbfc_pkg::NUM_PLANES-1:0] planes;

  // link[p] feeds cell p; link[NUM_PLANES] is the output register
  cbfc_pkg::item_t link [cbfc_pkg::NUM_PLANES+1];
  logic            link_ready [cbfc_pkg::NUM_PLANES+1];

  cbfc_pkg::item_t front;
  cbfc_pkg::coord_t cx;
  cbfc_pkg::coord_t cz;
  logic            front_ready;

  // Matrix registers and plane setup.
  cbfc_plane u_plane (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .planes    (planes)
  );

  // Coordinate stage: scale grid position to world box edges.
  assign cx          = cbfc_pkg::coord_t'(chunk.chunk_x);
  assign cz          = cbfc_pkg::coord_t'(chunk.chunk_z);
  assign front_ready = !front.valid || link_ready[0];
  assign chunk.ready = front_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      front.valid <= 1'b0;
    end else if (front_ready) begin
      front.valid <= chunk.valid;
    end
    if (front_ready && chunk.valid) begin
      front.vis <= 1'b1;
      front.x0  <= cx * cbfc_pkg::coord_t'(cbfc_pkg::CHUNK_SIZE);
      front.x1  <= cx * cbfc_pkg::coord_t'(cbfc_pkg::CHUNK_SIZE)
                   + cbfc_pkg::coord_t'(cbfc_pkg::CHUNK_SIZE);
      front.z0  <= cz * cbfc_pkg::coord_t'(cbfc_pkg::CHUNK_SIZE);
      front.z1  <= cz * cbfc_pkg::coord_t'(cbfc_pkg::CHUNK_SIZE)
                   + cbfc_pkg::coord_t'(cbfc_pkg::CHUNK_SIZE);
    end
  end

  assign link[0] = front;

  // Row of plane cells; each drops the visible bit when its plane rejects the box.
  for (genvar p = 0; p < cbfc_pkg::NUM_PLANES; p++) begin : g_cell
    cbfc_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .plane      (planes[p]),
      .up         (link[p]),
      .up_ready   (link_ready[p]),
      .down       (link[p+1]),
      .down_ready (link_ready[p+1])
    );
  end

  // Last cell's second stage is the output register.
  assign result.valid                      = link[cbfc_pkg::NUM_PLANES].valid;
  assign result.visible                    = link[cbfc_pkg::NUM_PLANES].vis;
  assign link_ready[cbfc_pkg::NUM_PLANES]  = result.ready;

endmodule

### hw/rtl/cbfc_check.sv
`include "chunk_box_frustum_cull_assert.svh"

module cbfc_check (
  input logic clk,
  input logic rst,
  input logic req_ready,
  input logic rsp_valid,
  input logic rsp_ready,
  input logic rsp_visible
);

  // pipe is empty right after reset
  `CBFC_ASSERT_NEXT_ALWAYS(a_reset_empty, clk, rst, !rsp_valid)
  // a stalled result stays offered
  `CBFC_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid)
  // and keeps its verdict
  `CBFC_ASSERT_NEXT(a_rsp_stable, clk, rst, rsp_valid && !rsp_ready, $stable(rsp_visible))
  // no back-pressure upstream unless the receiver holds a result
  `CBFC_ASSERT_NOW(a_req_free, clk, rst, !rsp_valid || rsp_ready, req_ready)

endmodule

bind chunk_box_frustum_cull cbfc_check u_cbfc_check (
  .clk         (clk),
  .rst         (rst),
  .req_ready   (chunk.ready),
  .rsp_valid   (result.valid),
  .rsp_ready   (result.ready),
  .rsp_visible (result.visible)
);

### tb/chunk_box_frustum_cull_test.sv
module chunk_box_frustum_cull_test;
  import cbfc_pkg::*;

  // Register map of the cull block, in port index order.
  typedef enum logic [CFG_IDX_W-1:0] {
    COL0_ROWS01,
    COL0_ROWS23,
    COL1_ROWS01,
    COL1_ROWS23,
    COL2_ROWS01,
    COL2_ROWS23,
    COL3_ROWS01,
    COL3_ROWS23
  } cfg_reg_e;

  // Kinds of view-projection matrix loaded between phases.
  typedef enum int {
    STYLE_ZERO,       // every entry zero: all six planes flat
    STYLE_OPEN,       // unit normals, huge d: every chunk passes
    STYLE_OPEN_FLAT,  // as open, but the z planes lose their normal
    STYLE_VIEW,       // camera-like: row 3 dominates, translation larger
    STYLE_FLAT,       // camera-like with one plane forced flat
    STYLE_FULL,       // every entry random over the full Q16.16 range
    STYLE_EXTREME_A,  // rows 0 and 2 at the negative limit, rows 1 and 3 at the positive
    STYLE_EXTREME_B   // the reverse
  } matrix_style_e;

  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_e;

  // Q16.16 entries indexed [column][row].
  typedef logic signed [31:0] q16_grid_t [4][4];

  // Bit p set: plane p takes row 3 minus its row, else row 3 plus its row.
  // Plane p uses row p/2.
  localparam bit [5:0] ROW_SUBTRACTED = 6'b011001;

  typedef struct {
    logic signed [CHUNK_W-1:0] x;
    logic signed [CHUNK_W-1:0] z;
    bit                        visible;
  } cull_verdict_t;

  // Holds a private copy of the matrix registers, predicts the verdict of every
  // accepted request and checks the results against it in order.
  class cull_scoreboard;
    logic [CFG_W-1:0] matrix_regs [REG_N];
    cull_verdict_t    verdicts_due [$];
    int               mismatches;

    function void load_identity();
      matrix_regs[COL0_ROWS01] = 64'h0000_0000_0001_0000;
      matrix_regs[COL0_ROWS23] = 64'h0000_0000_0000_0000;
      matrix_regs[COL1_ROWS01] = 64'h0001_0000_0000_0000;
      matrix_regs[COL1_ROWS23] = 64'h0000_0000_0000_0000;
      matrix_regs[COL2_ROWS01] = 64'h0000_0000_0000_0000;
      matrix_regs[COL2_ROWS23] = 64'h0000_0000_0001_0000;
      matrix_regs[COL3_ROWS01] = 64'h0000_0000_0000_0000;
      matrix_regs[COL3_ROWS23] = 64'h0001_0000_0000_0000;
    endfunction

    function void write_reg(cfg_reg_e idx, logic [CFG_W-1:0] data);
      matrix_regs[idx] = data;
    endfunction

    function longint matrix_entry(int col, int row);
      logic [CFG_W-1:0]   w;
      logic signed [31:0] e;
      w = matrix_regs[col * 2 + row / 2];
      e = (row % 2) ? w[63:32] : w[31:0];
      return longint'(e);
    endfunction

    function bit predict_visible(logic signed [CHUNK_W-1:0] cx,
                                 logic signed [CHUNK_W-1:0] cz);
      longint xs [2];
      longint ys [2];
      longint zs [2];
      longint coef [4];
      longint r3, ri, v;
      bit     hit;
      xs[0] = longint'(cx) * longint'(CHUNK_SIZE);
      xs[1] = xs[0] + longint'(CHUNK_SIZE);
      ys[0] = 0;
      ys[1] = longint'(BOX_TOP);
      zs[0] = longint'(cz) * longint'(CHUNK_SIZE);
      zs[1] = zs[0] + longint'(CHUNK_SIZE);
      for (int p = 0; p < 6; p++) begin
        for (int k = 0; k < 4; k++) begin
          r3 = matrix_entry(k, 3);
          ri = matrix_entry(k, p / 2);
          coef[k] = ROW_SUBTRACTED[p] ? r3 - ri : r3 + ri;
        end
        // a plane without a normal culls everything
        if (coef[0] == 0 && coef[1] == 0 && coef[2] == 0) return 1'b0;
        hit = 1'b0;
        for (int c = 0; c < 8; c++) begin
          v = coef[0] * xs[c & 1] + coef[1] * ys[(c >> 1) & 1]
            + coef[2] * zs[(c >> 2) & 1] + coef[3];
          if (v > 0) hit = 1'b1;
        end
        if (!hit) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void note_request(logic signed [CHUNK_W-1:0] cx,
                               logic signed [CHUNK_W-1:0] cz);
      cull_verdict_t verdict;
      verdict.x = cx;
      verdict.z = cz;
      verdict.visible = predict_visible(cx, cz);
      verdicts_due.push_back(verdict);
    endfunction

    function void check_result(logic got);
      cull_verdict_t want;
      if (verdicts_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result visible=%0b arrived with no request pending", got);
        return;
      end
      want = verdicts_due.pop_front();
      if (got !== want.visible) begin
        mismatches++;
        if (mismatches <= 10)
          $display("chunk (%0d,%0d): visible expected %0b, got %0b",
                   want.x, want.z, want.visible, got);
      end
    endfunction

    function int pending();
      return verdicts_due.size();
    endfunction

    function int failures();
      return mismatches + verdicts_due.size();
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  cbfc_req_if chunk_if ();
  cbfc_rsp_if result_if ();

  cull_scoreboard verdicts = new();

  // Idling knobs, changed per phase.
  bit sender_slow;
  bit receiver_slow;
  int idle_pct;

  chunk_box_frustum_cull u_top (
    .clk       (clk),
    .rst       (rst),
    .chunk     (chunk_if),
    .result    (result_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop in case a handshake never completes.
  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic bit roll_idle(bit slow);
    return slow && ($urandom_range(99) < idle_pct);
  endfunction

  function automatic int rand_span(int span);
    return int'($urandom_range(2 * span)) - span;
  endfunction

  // Mostly chunks around the origin where the view planes cross, some farther
  // out, and some over the whole 16-bit field so every bit toggles.
  function automatic logic signed [CHUNK_W-1:0] pick_coord();
    int r;
    int v;
    r = $urandom_range(99);
    if (r < 70) v = rand_span(40);
    else if (r < 85) v = rand_span(1000);
    else v = $urandom;
    return v[CHUNK_W-1:0];
  endfunction

  function automatic void fill_matrix(matrix_style_e style, output q16_grid_t g);
    int p;
    for (int col = 0; col < 4; col++)
      for (int row = 0; row < 4; row++)
        g[col][row] = '0;
    case (style)
      STYLE_OPEN, STYLE_OPEN_FLAT: begin
        g[0][0] = 1;
        g[1][1] = 1;
        g[2][2] = (style == STYLE_OPEN) ? 1 : 0;
        g[3][3] = 32'sh7FFF_FFFF;
      end
      STYLE_VIEW, STYLE_FLAT: begin
        for (int col = 0; col < 3; col++) begin
          for (int row = 0; row < 3; row++) g[col][row] = rand_span(1 << 16);
          g[col][3] = rand_span(1 << 18);
        end
        for (int row = 0; row < 4; row++) g[3][row] = rand_span(1 << 24);
        if (style == STYLE_FLAT) begin
          // cancel the normal of one plane against row 3
          p = $urandom_range(5);
          for (int col = 0; col < 3; col++)
            g[col][p / 2] = ROW_SUBTRACTED[p] ? g[col][3] : -g[col][3];
        end
      end
      STYLE_FULL: begin
        for (int col = 0; col < 4; col++)
          for (int row = 0; row < 4; row++)
            g[col][row] = $urandom;
      end
      STYLE_EXTREME_A, STYLE_EXTREME_B: begin
        for (int col = 0; col < 4; col++)
          for (int row = 0; row < 4; row++)
            g[col][row] = ((row % 2 == 0) == (style == STYLE_EXTREME_A)) ?
                          32'sh8000_0000 : 32'sh7FFF_FFFF;
      end
      default: ;
    endcase
  endfunction

  task automatic set_idling(idle_mode_e mode);
    sender_slow   = (mode == IDLE_SENDER) || (mode == IDLE_BOTH);
    receiver_slow = (mode == IDLE_RECEIVER) || (mode == IDLE_BOTH);
    idle_pct      = (mode == IDLE_BOTH) ? 7 : 79;
  endtask

  // Drive one register at a falling edge; the block takes it at the next rise.
  task automatic write_reg(cfg_reg_e idx, logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    verdicts.write_reg(idx, data);
  endtask

  // Write all eight registers back to back, then drop the enable.
  task automatic load_matrix(input q16_grid_t g);
    write_reg(COL0_ROWS01, {g[0][1], g[0][0]});
    write_reg(COL0_ROWS23, {g[0][3], g[0][2]});
    write_reg(COL1_ROWS01, {g[1][1], g[1][0]});
    write_reg(COL1_ROWS23, {g[1][3], g[1][2]});
    write_reg(COL2_ROWS01, {g[2][1], g[2][0]});
    write_reg(COL2_ROWS23, {g[2][3], g[2][2]});
    write_reg(COL3_ROWS01, {g[3][1], g[3][0]});
    write_reg(COL3_ROWS23, {g[3][3], g[3][2]});
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Present one request, idling first if the dice say so, and hold it until
  // the block takes it. Valid stays high into the next call, so back-to-back
  // requests never see a low pulse.
  task automatic send_chunk(logic signed [CHUNK_W-1:0] x, logic signed [CHUNK_W-1:0] z);
    @(negedge clk);
    while (roll_idle(sender_slow)) begin
      chunk_if.valid = 1'b0;
      @(negedge clk);
    end
    chunk_if.valid   = 1'b1;
    chunk_if.chunk_x = x;
    chunk_if.chunk_z = z;
    do @(posedge clk); while (!chunk_if.ready);
  endtask

  // Stop sending, wait for every pending result, then let the pipe settle.
  task automatic wait_drained();
    @(negedge clk);
    chunk_if.valid = 1'b0;
    while (verdicts.pending() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  // Receiver: decide ready at time zero, then once per cycle at the falling edge.
  always begin
    result_if.ready = !roll_idle(receiver_slow);
    @(negedge clk);
  end

  // Sample both handshakes at the rising edge: note accepted requests,
  // check accepted results.
  always @(posedge clk) begin
    if (!rst) begin
      if (chunk_if.valid && chunk_if.ready)
        verdicts.note_request(chunk_if.chunk_x, chunk_if.chunk_z);
      if (result_if.valid && result_if.ready)
        verdicts.check_result(result_if.visible);
    end
  end

  initial begin
    q16_grid_t     grid;
    matrix_style_e phase_style [10];

    phase_style = '{STYLE_VIEW, STYLE_FULL, STYLE_FLAT, STYLE_EXTREME_A, STYLE_VIEW,
                    STYLE_FULL, STYLE_EXTREME_B, STYLE_FLAT, STYLE_VIEW, STYLE_VIEW};

    // Drive every input to a known value before the first edge.
    rst              = 1'b1;
    cfg_we           = 1'b0;
    cfg_index        = COL0_ROWS01;
    cfg_data         = '0;
    chunk_if.valid   = 1'b0;
    chunk_if.chunk_x = '0;
    chunk_if.chunk_z = '0;
    set_idling(IDLE_NONE);
    verdicts.load_identity();

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Identity matrix out of reset: only chunks touching the origin pass.
    // Cover both signs next to zero and the corners of the coordinate field.
    send_chunk(0, 0);
    send_chunk(-1, -1);
    send_chunk(-1, 0);
    send_chunk(0, -1);
    send_chunk(1, 0);
    send_chunk(0, 1);
    send_chunk(-2, 0);
    send_chunk(32767, 32767);
    send_chunk(-32768, -32768);
    send_chunk(32767, -32768);
    send_chunk(-32768, 32767);
    send_chunk(0, -32768);
    wait_drained();

    // All-zero matrix: every plane is flat, so every chunk is culled.
    fill_matrix(STYLE_ZERO, grid);
    load_matrix(grid);
    send_chunk(0, 0);
    send_chunk(5, -7);
    wait_drained();

    // Wide-open planes: everything passes, extremes included.
    fill_matrix(STYLE_OPEN, grid);
    load_matrix(grid);
    send_chunk(0, 0);
    send_chunk(32767, -32768);
    send_chunk(-32768, 32767);
    wait_drained();

    // Same planes, but the z pair lost its normal: culled despite a huge d.
    fill_matrix(STYLE_OPEN_FLAT, grid);
    load_matrix(grid);
    send_chunk(0, 0);
    send_chunk(32767, 32767);
    send_chunk(-1, -1);
    wait_drained();

    // Random phases: new matrix and idling pattern each time, drained between.
    for (int phase = 0; phase < 10; phase++) begin
      set_idling(idle_mode_e'(phase % 4));
      fill_matrix(phase_style[phase], grid);
      load_matrix(grid);
      for (int n = 0; n < 130; n++) begin
        // hold off once mid-phase until the pipe is empty
        if (phase == 2 && n == 65) wait_drained();
        send_chunk(pick_coord(), pick_coord());
      end
      wait_drained();
    end

    if (verdicts.failures() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
